// ===== rtl/grwi_pkg.sv =====
`timescale 1ns / 1ps
package grwi_pkg;

  localparam int MAP_DIM     = 64;
  localparam int TILE_PIXELS = 64;
  localparam int ANGLE_BITS  = 12;
  localparam int FRAC_BITS   = 8;

  localparam int CELL_W     = $clog2(MAP_DIM);
  localparam int MAP_AW     = 2 * CELL_W;
  localparam int MAP_DEPTH  = MAP_DIM * MAP_DIM;
  localparam int TILE_SHIFT = $clog2(TILE_PIXELS) + FRAC_BITS;
  localparam int TQ         = TILE_PIXELS << FRAC_BITS;
  localparam int PX1        = 1 << FRAC_BITS;
  localparam int MAG_W      = TILE_SHIFT + 1;
  localparam int SIN_W      = 31;
  localparam int QA_W       = ANGLE_BITS - 1;
  localparam int QUARTER    = 1 << (ANGLE_BITS - 2);
  localparam int PROD_W     = MAG_W + SIN_W;
  localparam int RATIO_W    = 41;
  localparam int COORD_W    = 44;
  localparam int PLAYER_W   = 21;
  localparam int DIM_W      = 7;
  localparam int OUT_W      = 24;
  localparam int CNT_W      = $clog2(PROD_W + 1);

  localparam longint unsigned PI_Q30 = 64'd3373259426;

  // register indexes on the configuration port
  localparam logic [1:0] REG_PLAYER_X   = 2'd0;
  localparam logic [1:0] REG_PLAYER_Y   = 2'd1;
  localparam logic [1:0] REG_MAP_WIDTH  = 2'd2;
  localparam logic [1:0] REG_MAP_HEIGHT = 2'd3;

  // input item kinds
  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_CAST  = 1'b1;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SIN_S,
    ST_SIN_C,
    ST_SIN_W,
    ST_SETUP,
    ST_DIV_OFS,
    ST_DIV_STEP,
    ST_CHECK,
    ST_READ,
    ST_DONE
  } st_t;

  typedef logic [SIN_W-1:0] sin_tab_t [0:(1<<QA_W)-1];

  // shift-subtract quotient for the series terms, evaluated at elaboration
  function automatic longint unsigned series_div(longint unsigned n, longint unsigned d);
    longint unsigned quo;
    longint unsigned rem;
    int i;
    quo = '0;
    rem = '0;
    for (i = 63; i >= 0; i--) begin
      rem = {rem[62:0], n[i]};
      if (rem >= d) begin
        rem = rem - d;
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  // quarter-wave sine in Q30, Taylor series through the x^13 term
  function automatic sin_tab_t build_sin_tab();
    sin_tab_t tab;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint sum;
    int r;
    int k;
    for (r = 0; r < (1 << QA_W); r++) begin
      if (r <= QUARTER) begin
        x = (longint'(r) * PI_Q30) >> (ANGLE_BITS - 1);
        x2 = (x * x) >> 30;
        term = x;
        sum = longint'(x);
        for (k = 1; k <= 6; k++) begin
          term = series_div((term * x2) >> 30, 64'((2 * k) * (2 * k + 1)));
          if (k[0]) sum = sum - longint'(term);
          else sum = sum + longint'(term);
        end
        if (sum < 0) sum = 0;
        if (sum > (longint'(1) << 30)) sum = longint'(1) << 30;
        tab[r] = SIN_W'(sum);
      end else begin
        tab[r] = '0;
      end
    end
    return tab;
  endfunction

endpackage

// ===== rtl/grwi_ram.sv =====
`timescale 1ns / 1ps
module grwi_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/grwi_sin_rom.sv =====
`timescale 1ns / 1ps
module grwi_sin_rom import grwi_pkg::*; (
  input  logic             clk,
  input  logic [QA_W-1:0]  addr,
  output logic [SIN_W-1:0] q
);

  localparam sin_tab_t SIN_TAB = build_sin_tab();

  // registered table lookup
  always_ff @(posedge clk) begin
    q <= SIN_TAB[addr];
  end

endmodule

// ===== rtl/grwi_div.sv =====
`timescale 1ns / 1ps
module grwi_div import grwi_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [MAG_W-1:0]   mag,
  input  logic [SIN_W-1:0]   num,
  input  logic [SIN_W-1:0]   den,
  output logic               done,
  output logic [RATIO_W-1:0] quot
);

  localparam logic [PROD_W-1:0] RATIO_LIM = PROD_W'(1) << (RATIO_W - 1);

  logic [PROD_W-1:0] prod;
  logic [PROD_W-1:0] q_acc;
  logic [SIN_W-1:0]  rem;
  logic [SIN_W-1:0]  den_r;
  logic [CNT_W-1:0]  cnt;
  logic              running;
  logic [SIN_W:0]    rem_sh;
  logic              ge;

  // one restoring step: bring down the next product bit
  always_comb begin
    rem_sh = {rem, prod[PROD_W-1]};
    ge = rem_sh >= {1'b0, den_r};
  end

  // control: count quotient bits, pulse done after the last one
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= running && (cnt == CNT_W'(1));
      if (start) begin
        running <= 1'b1;
        cnt <= CNT_W'(PROD_W);
      end else if (running) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) running <= 1'b0;
      end
    end
  end

  // datapath: multiply once, then shift out one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (start) begin
      prod <= PROD_W'(mag) * PROD_W'(num);
      den_r <= den;
      rem <= '0;
      q_acc <= '0;
    end else if (running) begin
      prod <= {prod[PROD_W-2:0], 1'b0};
      rem <= ge ? SIN_W'(rem_sh - {1'b0, den_r}) : rem_sh[SIN_W-1:0];
      q_acc <= {q_acc[PROD_W-2:0], ge};
    end
  end

  // clamp the ratio
  assign quot = (q_acc > RATIO_LIM) ? RATIO_LIM[RATIO_W-1:0] : q_acc[RATIO_W-1:0];

endmodule

// ===== rtl/grid_ray_wall_intersect.sv =====
`timescale 1ns / 1ps
// channel   | dir | handshake              | payload
// s_*       | in  | s_tvalid / s_tready    | tuser: kind; tdata: cell_index, cell_wall, angle
// m_*       | out | m_tvalid / m_tready    | tdata: facing, hit flags, hit coordinates
// APB       | in  | psel & penable & pready| player_x, player_y, map_width, map_height
//
// A map write is taken in the idle state. A cast runs the sine lookups, the side setup
// and up to four ratio divisions (in the shared divider, one quotient bit per cycle),
// then tests cells, one map RAM read each, and ends each walk before the result loads.
// After reset the map RAM is swept to open floor, all 4096 cells, with s_tready low.
// A finished result waits in the output register; the next item is taken meanwhile.
module grid_ray_wall_intersect import grwi_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [31:0]  s_tdata,   // cell_index[11:0], cell_wall[12], angle[24:13]
  input  logic         s_tuser,   // kind[0]
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [103:0] m_tdata,   // faces_down[0], faces_right[1], horiz_found[2],
                                  // horiz_x[26:3], horiz_y[50:27], vert_found[51],
                                  // vert_x[75:52], vert_y[99:76]
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  localparam logic signed [COORD_W-1:0] TQ_S  = COORD_W'(TQ);
  localparam logic signed [COORD_W-1:0] PX1_S = COORD_W'(PX1);

  st_t state, state_next;

  logic [PLAYER_W-1:0] player_x, player_y;
  logic [DIM_W-1:0]    map_width, map_height;
  logic [DIM_W-1:0]    dim_wr;

  logic [ANGLE_BITS-1:0] angle_r;
  logic [SIN_W-1:0]      sin_r, cos_r, rom_q;
  logic [QA_W-1:0]       rom_addr;
  logic                  side;
  logic signed [COORD_W-1:0] t_main, t_other, step_other;
  logic                  h_found, v_found;
  logic [OUT_W-1:0]      hx, hy, vx, vy;
  logic [MAP_AW-1:0]     clr_cnt;

  logic                  down, right, dir_main, dir_other;
  logic [SIN_W-1:0]      num, den;
  logic [PLAYER_W-1:0]   p_main, p_other;
  logic signed [COORD_W-1:0] init_main, d_main, q_s, signed_q, lim_main, lim_other;
  logic signed [COORD_W-1:0] pt_main, cx, cy;
  logic [MAG_W-1:0]      mag, div_mag;
  logic                  div_start, div_done;
  logic [RATIO_W-1:0]    div_quot;
  logic                  in_bounds, off_map, load_out;
  logic [DIM_W-1:0]      col, row;
  logic                  ram_we, ram_wdata, ram_q;
  logic [MAP_AW-1:0]     ram_waddr, ram_raddr;
  logic                  cfg_wr, in_acc;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign in_acc = s_tvalid && s_tready;
  assign s_tready = (state == ST_IDLE);

  // configuration registers, map sizes clamped to the map store
  assign dim_wr = (pwdata[DIM_W-1:0] > DIM_W'(MAP_DIM)) ? DIM_W'(MAP_DIM) : pwdata[DIM_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      player_x <= '0;
      player_y <= '0;
      map_width <= DIM_W'(MAP_DIM);
      map_height <= DIM_W'(MAP_DIM);
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_PLAYER_X:   player_x <= pwdata[PLAYER_W-1:0];
        REG_PLAYER_Y:   player_y <= pwdata[PLAYER_W-1:0];
        REG_MAP_WIDTH:  map_width <= dim_wr;
        REG_MAP_HEIGHT: map_height <= dim_wr;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_PLAYER_X:   prdata = 32'(player_x);
      REG_PLAYER_Y:   prdata = 32'(player_y);
      REG_MAP_WIDTH:  prdata = 32'(map_width);
      REG_MAP_HEIGHT: prdata = 32'(map_height);
      default:        prdata = '0;
    endcase
  end

  // facing flags and per-side selection
  always_comb begin
    down = (angle_r != '0) && !angle_r[ANGLE_BITS-1];
    right = (angle_r < ANGLE_BITS'(QUARTER)) || (angle_r > ANGLE_BITS'(3 * QUARTER));
    dir_main = side ? right : down;
    dir_other = side ? down : right;
    num = side ? sin_r : cos_r;
    den = side ? cos_r : sin_r;
    p_main = side ? player_x : player_y;
    p_other = side ? player_y : player_x;
    lim_main = COORD_W'(side ? map_width : map_height) << TILE_SHIFT;
    lim_other = COORD_W'(side ? map_height : map_width) << TILE_SHIFT;
  end

  // sine lookups: quadrant picks direct or complementary index
  always_comb begin
    if ((state == ST_SIN_S) ? angle_r[ANGLE_BITS-2] : !angle_r[ANGLE_BITS-2])
      rom_addr = QA_W'(QUARTER) - QA_W'(angle_r[ANGLE_BITS-3:0]);
    else
      rom_addr = QA_W'(angle_r[ANGLE_BITS-3:0]);
  end

  grwi_sin_rom u_rom (
    .clk  (clk),
    .addr (rom_addr),
    .q    (rom_q)
  );

  // first grid line on the main axis and the distance to it
  always_comb begin
    init_main = COORD_W'({p_main[PLAYER_W-1:TILE_SHIFT], TILE_SHIFT'(0)})
                + (dir_main ? TQ_S : '0);
    d_main = init_main - COORD_W'(p_main);
    mag = MAG_W'(d_main[COORD_W-1] ? -d_main : d_main);
    div_mag = (state == ST_SETUP) ? mag : MAG_W'(TQ);
    div_start = ((state == ST_SETUP) && (den != '0)) || ((state == ST_DIV_OFS) && div_done);
    q_s = COORD_W'(div_quot);
    signed_q = dir_other ? q_s : -q_s;
  end

  grwi_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .mag   (div_mag),
    .num   (num),
    .den   (den),
    .done  (div_done),
    .quot  (div_quot)
  );

  // cell test for the current touch point
  always_comb begin
    pt_main = t_main - (dir_main ? '0 : PX1_S);
    cx = side ? pt_main : t_other;
    cy = side ? t_other : pt_main;
    col = cx[TILE_SHIFT+DIM_W-1:TILE_SHIFT];
    row = cy[TILE_SHIFT+DIM_W-1:TILE_SHIFT];
    in_bounds = !t_main[COORD_W-1] && !t_other[COORD_W-1]
                && (t_main <= lim_main) && (t_other <= lim_other);
    off_map = cx[COORD_W-1] || cy[COORD_W-1] || (col >= map_width) || (row >= map_height);
    ram_raddr = {row[CELL_W-1:0], col[CELL_W-1:0]};
  end

  // map store write port: clearing sweep or map-write items
  always_comb begin
    ram_we = (state == ST_CLEAR) || (in_acc && (s_tuser == KIND_WRITE));
    ram_waddr = (state == ST_CLEAR) ? clr_cnt : s_tdata[MAP_AW-1:0];
    ram_wdata = (state == ST_CLEAR) ? 1'b0 : s_tdata[12];
  end

  grwi_ram #(.WIDTH(1), .DEPTH(MAP_DEPTH)) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_q)
  );

  assign load_out = (state == ST_DONE) && (!m_tvalid || m_tready);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR:    if (clr_cnt == '1) state_next = ST_IDLE;
      ST_IDLE:     if (in_acc && (s_tuser == KIND_CAST)) state_next = ST_SIN_S;
      ST_SIN_S:    state_next = ST_SIN_C;
      ST_SIN_C:    state_next = ST_SIN_W;
      ST_SIN_W:    state_next = ST_SETUP;
      ST_SETUP: begin
        if (den != '0) state_next = ST_DIV_OFS;
        else if (side) state_next = ST_DONE;
      end
      ST_DIV_OFS:  if (div_done) state_next = ST_DIV_STEP;
      ST_DIV_STEP: if (div_done) state_next = ST_CHECK;
      ST_CHECK: begin
        if (in_bounds && !off_map) state_next = ST_READ;
        else state_next = side ? ST_DONE : ST_SETUP;
      end
      ST_READ: begin
        if (ram_q) state_next = side ? ST_DONE : ST_SETUP;
        else state_next = ST_CHECK;
      end
      ST_DONE:     if (load_out) state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      clr_cnt <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) clr_cnt <= clr_cnt + MAP_AW'(1);
      if (load_out) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

  // walk datapath
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        angle_r <= s_tdata[24:13];
        side <= 1'b0;
        h_found <= 1'b0;
        v_found <= 1'b0;
        hx <= '0;
        hy <= '0;
        vx <= '0;
        vy <= '0;
      end
      ST_SIN_C: sin_r <= rom_q;
      ST_SIN_W: cos_r <= rom_q;
      ST_SETUP: begin
        t_main <= init_main;
        if (den == '0) side <= 1'b1;
      end
      ST_DIV_OFS: if (div_done) t_other <= COORD_W'(p_other) + signed_q;
      ST_DIV_STEP: if (div_done) step_other <= signed_q;
      ST_CHECK: begin
        if (!in_bounds) begin
          side <= 1'b1;
        end else if (off_map) begin
          side <= 1'b1;
          if (side) begin
            v_found <= 1'b1;
            vx <= t_main[OUT_W-1:0];
            vy <= t_other[OUT_W-1:0];
          end else begin
            h_found <= 1'b1;
            hx <= t_other[OUT_W-1:0];
            hy <= t_main[OUT_W-1:0];
          end
        end
      end
      ST_READ: begin
        if (ram_q) begin
          side <= 1'b1;
          if (side) begin
            v_found <= 1'b1;
            vx <= t_main[OUT_W-1:0];
            vy <= t_other[OUT_W-1:0];
          end else begin
            h_found <= 1'b1;
            hx <= t_other[OUT_W-1:0];
            hy <= t_main[OUT_W-1:0];
          end
        end else begin
          t_main <= t_main + (dir_main ? TQ_S : -TQ_S);
          t_other <= t_other + step_other;
        end
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (load_out) begin
      m_tdata <= {4'b0, vy, vx, v_found, hy, hx, h_found, right, down};
    end
  end

endmodule

// ===== rtl/grwi_chk.sv =====
`timescale 1ns / 1ps
module grwi_chk (
  input logic         clk,
  input logic         rst,
  input logic         s_tvalid,
  input logic         s_tready,
  input logic         s_tuser,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [103:0] m_tdata,
  input logic         pready
);

  // map sweep runs right after reset
  a_clear_after_reset: assert property (@(posedge clk) $past(rst) |-> !s_tready)
    else $error("input taken during map sweep");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // a cast keeps the block busy
  a_cast_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tuser |=> !s_tready)
    else $error("input taken while a cast is running");

  // a cast yields no result on the next cycle
  a_cast_latency: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tuser && !m_tvalid |=> !m_tvalid)
    else $error("result appeared too early");

  a_pready: assert property (@(posedge clk) disable iff (rst) pready)
    else $error("pready low");

endmodule

bind grid_ray_wall_intersect grwi_chk u_chk (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .pready   (pready)
);

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
module tb;
  import grwi_pkg::*;

  localparam longint TQ_L  = longint'(TILE_PIXELS) << FRAC_BITS;
  localparam longint PX1_L = longint'(1) << FRAC_BITS;
  localparam longint RLIM  = longint'(1) << 40;
  localparam int     DRAIN = 600;

  typedef struct {
    logic        kind;
    logic [11:0] cell_idx;
    logic        wall;
    logic [11:0] ang;
  } ray_item_t;

  typedef struct {
    logic        down;
    logic        right;
    logic        hf;
    logic [23:0] hx;
    logic [23:0] hy;
    logic        vf;
    logic [23:0] vx;
    logic [23:0] vy;
  } hit_t;

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  logic [31:0]  s_tdata;   // cell_index[11:0], cell_wall[12], angle[24:13]
  logic         s_tuser;   // kind[0]
  logic         m_tvalid;
  logic         m_tready;
  logic [103:0] m_tdata;   // faces_down[0], faces_right[1], horiz_found[2],
                           // horiz_x[26:3], horiz_y[50:27], vert_found[51],
                           // vert_x[75:52], vert_y[99:76]
  logic         psel;
  logic         penable;
  logic         pwrite;
  logic [3:0]   paddr;
  logic [31:0]  pwdata;
  logic [31:0]  prdata;
  logic         pready;

  grid_ray_wall_intersect u_top (.*);

  // shadow of the block state
  logic   wall_bits [0:MAP_DEPTH-1];
  longint sin_q30 [0:QUARTER];
  longint pos_x, pos_y, width_t, height_t;

  ray_item_t item_q [$];
  hit_t      hit_q [$];
  ray_item_t cur_item;
  int        err_cnt = 0;
  int        s_gap, m_gap;
  bit        quiet;

  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  function automatic longint sine_val(longint unsigned r);
    longint unsigned x, x2, term;
    longint sum;
    x = (r * PI_Q30) / (longint'(QUARTER) * 2);
    x2 = (x * x) >> 30;
    term = x;
    sum = longint'(x);
    for (int k = 1; k <= 6; k++) begin
      term = ((term * x2) >> 30) / longint'((2 * k) * (2 * k + 1));
      if (k % 2 == 1) sum -= longint'(term);
      else sum += longint'(term);
    end
    if (sum < 0) sum = 0;
    if (sum > (longint'(1) << 30)) sum = longint'(1) << 30;
    return sum;
  endfunction

  function automatic longint scaled_ratio(longint mag, longint num, longint den);
    longint unsigned q;
    q = (longint'(mag) * num) / den;
    if (q > RLIM) q = RLIM;
    return longint'(q);
  endfunction

  function automatic bit cell_blocked(longint x, longint y);
    longint col, row;
    if (x < 0 || y < 0) return 1'b1;
    col = x / TQ_L;
    row = y / TQ_L;
    if (col >= width_t || row >= height_t) return 1'b1;
    return wall_bits[row * MAP_DIM + col];
  endfunction

  function automatic logic [23:0] clamp24(longint v);
    if (v > 8388607) v = 8388607;
    if (v < -8388608) v = -8388608;
    return v[23:0];
  endfunction

  // trace both grid-line walks for one ray angle
  function automatic hit_t trace_ray(logic [11:0] ang);
    hit_t   h;
    longint s, c, tx, ty, sx, sy, d, m, xmax, ymax;
    int     r;
    r = int'(ang[9:0]);
    s = ang[10] ? sin_q30[QUARTER - r] : sin_q30[r];
    c = ang[10] ? sin_q30[r] : sin_q30[QUARTER - r];
    h = '{default: '0};
    h.down = (ang > 0) && (ang < 2 * QUARTER);
    h.right = (ang < QUARTER) || (ang > 3 * QUARTER);
    xmax = width_t * TQ_L;
    ymax = height_t * TQ_L;
    if (s != 0) begin
      ty = (pos_y / TQ_L) * TQ_L + (h.down ? TQ_L : 0);
      d = ty - pos_y;
      m = scaled_ratio(d < 0 ? -d : d, c, s);
      tx = pos_x + (h.right ? m : -m);
      sy = h.down ? TQ_L : -TQ_L;
      m = scaled_ratio(TQ_L, c, s);
      sx = h.right ? m : -m;
      while (tx >= 0 && tx <= xmax && ty >= 0 && ty <= ymax) begin
        if (cell_blocked(tx, ty - (h.down ? 0 : PX1_L))) begin
          h.hf = 1'b1; h.hx = clamp24(tx); h.hy = clamp24(ty);
          break;
        end
        tx += sx;
        ty += sy;
      end
    end
    if (c != 0) begin
      tx = (pos_x / TQ_L) * TQ_L + (h.right ? TQ_L : 0);
      d = tx - pos_x;
      m = scaled_ratio(d < 0 ? -d : d, s, c);
      ty = pos_y + (h.down ? m : -m);
      sx = h.right ? TQ_L : -TQ_L;
      m = scaled_ratio(TQ_L, s, c);
      sy = h.down ? m : -m;
      while (tx >= 0 && tx <= xmax && ty >= 0 && ty <= ymax) begin
        if (cell_blocked(tx - (h.right ? 0 : PX1_L), ty)) begin
          h.vf = 1'b1; h.vx = clamp24(tx); h.vy = clamp24(ty);
          break;
        end
        tx += sx;
        ty += sy;
      end
    end
    return h;
  endfunction

  task automatic report_mismatch(string field, longint got, longint want);
    $display("mismatch %s: got %0h expected %0h at %0t", field, got, want, $realtime);
    err_cnt++;
  endtask

  // drive one register write over the configuration port and track it
  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    longint v;
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0;
    v = val[6:0];
    if (v > MAP_DIM) v = MAP_DIM;
    case (idx)
      REG_PLAYER_X:   pos_x = val[20:0];
      REG_PLAYER_Y:   pos_y = val[20:0];
      REG_MAP_WIDTH:  width_t = v;
      REG_MAP_HEIGHT: height_t = v;
    endcase
  endtask

  task automatic push_write(int idx, bit wall);
    ray_item_t it;
    it = '{kind: KIND_WRITE, cell_idx: idx[11:0], wall: wall, ang: 12'($urandom)};
    item_q.push_back(it);
  endtask

  task automatic push_cast(int ang);
    ray_item_t it;
    it = '{kind: KIND_CAST, cell_idx: 12'($urandom), wall: 1'($urandom), ang: ang[11:0]};
    item_q.push_back(it);
  endtask

  task automatic drain();
    while (item_q.size() != 0 || s_tvalid || hit_q.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  // random map content and casts; player mostly inside the map
  task automatic random_phase(int n, int wall_pct);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < 40)
        push_write($urandom_range(0, 4095), $urandom_range(0, 99) < wall_pct);
      else
        push_cast($urandom_range(0, 4095));
    end
  endtask

  // drive the input stream; predict on each accepted transaction
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tuser <= 1'b0;
      s_tdata <= '0;
      s_gap <= 0;
      for (int i = 0; i < MAP_DEPTH; i++) wall_bits[i] = 1'b0;
    end else if (!(s_tvalid && !s_tready)) begin
      if (s_tvalid) begin
        if (cur_item.kind == KIND_WRITE) wall_bits[cur_item.cell_idx] = cur_item.wall;
        else hit_q.push_back(trace_ray(cur_item.ang));
      end
      if (s_gap > 0) begin
        s_gap <= s_gap - 1;
        s_tvalid <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        s_gap <= $urandom_range(0, 6);
        s_tvalid <= 1'b0;
      end else if (item_q.size() != 0) begin
        cur_item = item_q.pop_front();
        s_tvalid <= 1'b1;
        s_tuser <= cur_item.kind;
        s_tdata <= {7'b0, cur_item.ang, cur_item.wall, cur_item.cell_idx};
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // accept results with random stalls and compare against the oldest prediction
  always @(posedge clk) begin
    hit_t want;
    if (rst) begin
      m_tready <= 1'b0;
      m_gap <= 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (hit_q.size() == 0) begin
          report_mismatch("unexpected result", m_tdata[63:0], 0);
        end else begin
          want = hit_q.pop_front();
          if (m_tdata[0] !== want.down) report_mismatch("faces_down", m_tdata[0], want.down);
          if (m_tdata[1] !== want.right) report_mismatch("faces_right", m_tdata[1], want.right);
          if (m_tdata[2] !== want.hf) report_mismatch("horiz_found", m_tdata[2], want.hf);
          if (m_tdata[26:3] !== want.hx) report_mismatch("horiz_x", m_tdata[26:3], want.hx);
          if (m_tdata[50:27] !== want.hy) report_mismatch("horiz_y", m_tdata[50:27], want.hy);
          if (m_tdata[51] !== want.vf) report_mismatch("vert_found", m_tdata[51], want.vf);
          if (m_tdata[75:52] !== want.vx) report_mismatch("vert_x", m_tdata[75:52], want.vx);
          if (m_tdata[99:76] !== want.vy) report_mismatch("vert_y", m_tdata[99:76], want.vy);
        end
      end
      if (m_gap > 0) begin
        m_gap <= m_gap - 1;
        m_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        m_gap <= $urandom_range(0, 6);
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // hard stop
  initial begin
    #20000000;
    $display("Verification failed");
    $finish;
  end

  initial begin
    for (int r = 0; r <= QUARTER; r++) sin_q30[r] = sine_val(r);
    pos_x = 0; pos_y = 0; width_t = 64; height_t = 64;
    quiet = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    rst = 1'b1;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed: open map from the corner, axis angles, corner cells
    push_cast(0); push_cast(1024); push_cast(2048); push_cast(3072);
    push_cast(1); push_cast(4095); push_cast(512); push_cast(1536);
    push_cast(2560); push_cast(3584);
    push_write(0, 1'b1); push_write(4095, 1'b1); push_write(65, 1'b1);
    drain();
    write_reg(REG_PLAYER_X, 32'd40000);
    write_reg(REG_PLAYER_Y, 32'd30000);
    push_cast(0); push_cast(1024); push_cast(2048); push_cast(3072);
    push_cast(300); push_cast(3800);
    push_write(65, 1'b0); push_write(0, 1'b0); push_cast(2600);
    drain();

    // several map shapes and viewer positions, extremes included
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          write_reg(REG_MAP_WIDTH, 32'd64); write_reg(REG_MAP_HEIGHT, 32'd64);
        end
        1: begin
          write_reg(REG_MAP_WIDTH, 32'd1); write_reg(REG_MAP_HEIGHT, 32'd1);
        end
        2: begin
          write_reg(REG_MAP_WIDTH, 32'h7f); write_reg(REG_MAP_HEIGHT, 32'd0);
        end
        3: begin
          write_reg(REG_MAP_WIDTH, 32'hffff_ffc0); write_reg(REG_MAP_HEIGHT, 32'd64);
          write_reg(REG_PLAYER_X, 32'h001f_ffff); write_reg(REG_PLAYER_Y, 32'hffff_ffff);
        end
        default: begin
          write_reg(REG_MAP_WIDTH, $urandom_range(1, 64));
          write_reg(REG_MAP_HEIGHT, $urandom_range(1, 64));
        end
      endcase
      if (ph != 3) begin
        write_reg(REG_PLAYER_X, $urandom_range(0, 32'(width_t * TQ_L)));
        write_reg(REG_PLAYER_Y, $urandom_range(0, 32'(height_t * TQ_L)));
      end
      if (ph == 5) quiet = 1'b1;
      random_phase(80, (ph % 2 == 0) ? 15 : 40);
      drain();
    end

    if (err_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
